// ----- design/tmes_pkg.sv -----
package tmes_pkg;

  localparam int unsigned MAX_EMIT   = 32;
  localparam int unsigned EMIT_W     = $clog2(MAX_EMIT + 1);
  localparam int unsigned OFFSET_MAX = 8191;

  localparam logic [8:0] ABSENT_CODE = 9'h1FF;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  localparam logic [1:0] KIND_EVENT   = 2'd0;
  localparam logic [1:0] KIND_QUEUED  = 2'd1;
  localparam logic [1:0] KIND_DROPPED = 2'd2;
  localparam logic [1:0] KIND_DONE    = 2'd3;

  typedef struct packed {
    logic [31:0] frame_time;
    logic [1:0]  length;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
  } entry_t;

  typedef struct packed {
    logic enqueue;
    logic tick;
    logic emit;
    logic done;
  } cmd_t;

  typedef struct packed {
    logic stop;
    logic due;
    logic out_free;
  } sts_t;

endpackage

// ----- design/tmes_ctrl.sv -----
module tmes_ctrl
  import tmes_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic opcode_i,
  input  sts_t sts_i,
  output logic in_ready_o,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_WAIT
  } state_e;

  state_e state_q, state_d;
  logic   take;

  assign in_ready_o = (state_q == S_IDLE) && sts_i.out_free;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o         = '0;
    cmd_o.enqueue = take && (opcode_i == OP_ENQUEUE);
    cmd_o.tick    = take && (opcode_i == OP_TICK);
    cmd_o.emit    = (state_q == S_EVAL) && sts_i.out_free && !sts_i.stop && sts_i.due;
    cmd_o.done    = (state_q == S_EVAL) && sts_i.out_free && (sts_i.stop || !sts_i.due);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.tick) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (cmd_o.emit) begin
          state_d = S_WAIT;
        end else if (cmd_o.done) begin
          state_d = S_IDLE;
        end
      end
      S_WAIT: begin
        state_d = S_EVAL;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- design/tmes_dp.sv -----
module tmes_dp
  import tmes_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH       = 32,
  parameter int unsigned MAX_PERIOD_FRAMES = 8192
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [7:0]        status_byte_i,
  input  logic signed [8:0] first_data_byte_i,
  input  logic signed [8:0] second_data_byte_i,
  input  logic [31:0]       frame_time_i,
  input  logic [13:0]       period_frames_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        result_kind_o,
  output logic [12:0]       frame_offset_o,
  output logic [1:0]        message_length_o,
  output logic [7:0]        out_status_byte_o,
  output logic [7:0]        out_first_data_o,
  output logic [7:0]        out_second_data_o,
  output logic              last_o
);

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PW = $clog2(MAX_PERIOD_FRAMES + 1);

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_q;
  entry_t wr_entry;

  logic [IW-1:0]     head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]     count_q, count_d;
  logic [EMIT_W-1:0] emitted_q, emitted_d;
  logic [PW-1:0]     period_q;
  logic [31:0]       base_q;
  logic [31:0]       period_sat;
  logic [31:0]       delta;
  logic [12:0]       offset;
  logic              full;
  logic              empty;
  logic              limit;
  logic              push;

  logic        out_valid_q, out_valid_d;
  logic [1:0]  kind_q, kind_d;
  logic [12:0] offset_q, offset_d;
  logic [1:0]  length_q, length_d;
  logic [7:0]  byte0_q, byte0_d, byte1_q, byte1_d, byte2_q, byte2_d;
  logic        last_q, last_d;

  assign full  = (count_q == CW'(QUEUE_DEPTH));
  assign empty = (count_q == '0);
  assign limit = (emitted_q == EMIT_W'(MAX_EMIT));
  assign push  = cmd_i.enqueue && !full;

  always_comb begin
    wr_entry            = '0;
    wr_entry.frame_time = frame_time_i;
    wr_entry.byte0      = status_byte_i;
    if (first_data_byte_i == ABSENT_CODE) begin
      wr_entry.length = 2'd1;
    end else if (second_data_byte_i == ABSENT_CODE) begin
      wr_entry.length = 2'd2;
      wr_entry.byte1  = first_data_byte_i[7:0];
    end else begin
      wr_entry.length = 2'd3;
      wr_entry.byte1  = first_data_byte_i[7:0];
      wr_entry.byte2  = second_data_byte_i[7:0];
    end
  end

  assign period_sat = (32'(period_frames_i) > 32'(MAX_PERIOD_FRAMES)) ?
                      32'(MAX_PERIOD_FRAMES) : 32'(period_frames_i);

  // offset of the head event relative to the period start
  assign delta = rd_q.frame_time + base_q;

  always_comb begin
    if (delta[31]) begin
      offset = '0;
    end else if (delta > 32'(OFFSET_MAX)) begin
      offset = 13'(OFFSET_MAX);
    end else begin
      offset = delta[12:0];
    end
  end

  assign sts_o.stop     = empty || limit;
  assign sts_o.due      = delta[31] || (delta < 32'(period_q));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    emitted_d = emitted_q;
    if (push) begin
      tail_d  = (tail_q == IW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
      count_d = count_q + 1'b1;
    end
    if (cmd_i.tick) begin
      emitted_d = '0;
    end
    if (cmd_i.emit) begin
      head_d    = (head_q == IW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
      count_d   = count_q - 1'b1;
      emitted_d = emitted_q + 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    offset_d    = offset_q;
    length_d    = length_q;
    byte0_d     = byte0_q;
    byte1_d     = byte1_q;
    byte2_d     = byte2_q;
    last_d      = last_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.enqueue || cmd_i.done) begin
      out_valid_d = 1'b1;
      offset_d    = '0;
      length_d    = '0;
      byte0_d     = '0;
      byte1_d     = '0;
      byte2_d     = '0;
      last_d      = 1'b1;
      if (cmd_i.done) begin
        kind_d = KIND_DONE;
      end else if (full) begin
        kind_d = KIND_DROPPED;
      end else begin
        kind_d = KIND_QUEUED;
      end
    end else if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      kind_d      = KIND_EVENT;
      offset_d    = offset;
      length_d    = rd_q.length;
      byte0_d     = rd_q.byte0;
      byte1_d     = rd_q.byte1;
      byte2_d     = rd_q.byte2;
      last_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      emitted_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      emitted_q   <= emitted_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    offset_q <= offset_d;
    length_q <= length_d;
    byte0_q  <= byte0_d;
    byte1_q  <= byte1_d;
    byte2_q  <= byte2_d;
    last_q   <= last_d;
    if (cmd_i.tick) begin
      period_q <= period_sat[PW-1:0];
      base_q   <= period_sat - frame_time_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[tail_q] <= wr_entry;
    end
    rd_q <= mem[head_q];
  end

  assign out_valid_o       = out_valid_q;
  assign result_kind_o     = kind_q;
  assign frame_offset_o    = offset_q;
  assign message_length_o  = length_q;
  assign out_status_byte_o = byte0_q;
  assign out_first_data_o  = byte1_q;
  assign out_second_data_o = byte2_q;
  assign last_o            = last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !empty && !limit)
    else $error("event popped from empty queue or past emit limit");

  a_event_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_valid_q && (kind_q == KIND_EVENT) && !last_q && (length_q != 2'd0))
    else $error("emitted event beat malformed");

endmodule

// ----- design/timestamped_midi_event_scheduler.sv -----
// timestamped midi event scheduler
// input channel (in_valid_i / in_ready_o): opcode_i selects enqueue or period tick.
//   enqueue: status byte plus up to two data bytes (all-ones code means absent),
//   stamped with frame_time_i, pushed into a QUEUE_DEPTH entry fifo.
//   one beat out: queued, or dropped when the fifo is full;
//   back-to-back enqueues run at one per cycle while the receiver keeps up.
// tick: frame_time_i is the period end, period_frames_i the length.
//   due events leave the head one beat each, then a closing beat with last_o set.
//   after each event the block passes a wait state, set by the registered fifo
//   read port (the head is reread after every pop).
//   at most 32 events per tick, the rest stay queued.
// output channel (out_valid_o / out_ready_i) is one output register.
//   a stalled receiver holds the beat; the block waits and no new input is taken.
// reset: fifo pointers and count cleared, output empty; fifo contents are left
//   as they are and never read before written, so no clearing pass is needed.
module timestamped_midi_event_scheduler
  import tmes_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH       = 32,
  parameter int unsigned MAX_PERIOD_FRAMES = 8192
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              opcode_i,
  input  logic [7:0]        status_byte_i,
  input  logic signed [8:0] first_data_byte_i,
  input  logic signed [8:0] second_data_byte_i,
  input  logic [31:0]       frame_time_i,
  input  logic [13:0]       period_frames_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        result_kind_o,
  output logic [12:0]       frame_offset_o,
  output logic [1:0]        message_length_o,
  output logic [7:0]        out_status_byte_o,
  output logic [7:0]        out_first_data_o,
  output logic [7:0]        out_second_data_o,
  output logic              last_o
);

  cmd_t cmd;
  sts_t sts;

  tmes_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  tmes_dp #(
    .QUEUE_DEPTH       (QUEUE_DEPTH),
    .MAX_PERIOD_FRAMES (MAX_PERIOD_FRAMES)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .status_byte_i      (status_byte_i),
    .first_data_byte_i  (first_data_byte_i),
    .second_data_byte_i (second_data_byte_i),
    .frame_time_i       (frame_time_i),
    .period_frames_i    (period_frames_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .result_kind_o      (result_kind_o),
    .frame_offset_o     (frame_offset_o),
    .message_length_o   (message_length_o),
    .out_status_byte_o  (out_status_byte_o),
    .out_first_data_o   (out_first_data_o),
    .out_second_data_o  (out_second_data_o),
    .last_o             (last_o)
  );

endmodule
